// ----- rtl/core/quadrature_frequency_tuner_core_assert.svh -----
// Assertion macros shared by the quadrature frequency tuner checkers.
// Plain SystemVerilog properties; no other dependencies.
`ifndef QUADRATURE_FREQUENCY_TUNER_CORE_ASSERT_SVH
`define QUADRATURE_FREQUENCY_TUNER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QFT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/qft_pkg.sv -----
// Package for the quadrature frequency tuner: widths, limits, codes,
// transition table and shared types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qft_pkg;

    localparam int FREQ_W    = 28;
    localparam int CH_W      = 2;
    localparam int STEP_W    = 25;
    localparam int PIN_W     = 2;
    localparam int ACC_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = STEP_W;

    localparam int DEF_NUM_CHANNELS     = 3;
    localparam int DEF_STEPS_PER_DETENT = 4;

    localparam logic [FREQ_W-1:0] FREQ_MIN = FREQ_W'(10000);
    localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(220000000);

    localparam logic signed [STEP_W-1:0] TUNING_STEP_RESET = STEP_W'(-100000);

    // Item kinds
    localparam logic FUNC_PIN_SAMPLE  = 1'b0;
    localparam logic FUNC_DIRECT_LOAD = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TUNING_STEP    = 1'b1;

    // Step per pin transition, indexed by {previous pair, current pair}
    localparam logic signed [1:0] QUAD_STEPS [16] = '{
         2'sd0,  2'sd1, -2'sd1,  2'sd0,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
         2'sd0, -2'sd1,  2'sd1,  2'sd0
    };

    typedef struct packed {
        logic              func;
        logic [PIN_W-1:0]  pin_pair;
        logic              tune_enable;
        logic [CH_W-1:0]   write_channel;
        logic [FREQ_W-1:0] write_freq;
    } item_t;

    // Decoder to frequency bank
    typedef struct packed {
        logic              load;      // direct write to a valid channel
        logic              detent;    // one detent to apply
        logic              up;        // detent adds the step (else subtracts)
        logic [CH_W-1:0]   ch;        // channel touched and reported
        logic [FREQ_W-1:0] load_freq; // unclamped direct-write value
    } freq_cmd_t;

    function automatic logic [FREQ_W-1:0] reset_freq(input int unsigned idx);
        logic [FREQ_W-1:0] f;
        case (idx)
            0:       f = FREQ_W'(10000000);
            1:       f = FREQ_W'(14000000);
            2:       f = FREQ_W'(21000000);
            default: f = FREQ_W'(10000000);
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qft_intf.sv -----
// Valid/ready channel interfaces for the quadrature frequency tuner.
// Depends on qft_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface qft_item_if;
    import qft_pkg::*;
    logic              valid;
    logic              ready;
    logic              func;
    logic [PIN_W-1:0]  pin_pair;
    logic              tune_enable;
    logic [CH_W-1:0]   write_channel;
    logic [FREQ_W-1:0] write_freq;

    modport source (output valid, func, pin_pair, tune_enable, write_channel, write_freq,
                    input ready);
    modport sink   (input valid, func, pin_pair, tune_enable, write_channel, write_freq,
                    output ready);
endinterface

interface qft_result_if;
    import qft_pkg::*;
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   out_channel;
    logic [FREQ_W-1:0] out_freq;
    logic              changed;

    modport source (output valid, out_channel, out_freq, changed, input ready);
    modport sink   (input valid, out_channel, out_freq, changed, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/qft_step_dec.sv -----
// Encoder transition decoder: pin history, step accumulator, detent detect.
// Depends on qft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qft_step_dec #(
    parameter int NUM_CHANNELS     = qft_pkg::DEF_NUM_CHANNELS,
    parameter int STEPS_PER_DETENT = qft_pkg::DEF_STEPS_PER_DETENT
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        fire,
    input  wire qft_pkg::item_t        item,
    input  wire  [qft_pkg::CH_W-1:0]   active_channel,
    output qft_pkg::freq_cmd_t         cmd
);
    import qft_pkg::*;

    localparam logic signed [ACC_W-1:0] DETENT_POS = ACC_W'(STEPS_PER_DETENT);
    localparam logic signed [ACC_W-1:0] DETENT_NEG = -DETENT_POS;

    logic [PIN_W-1:0]        last_pins_reg, last_pins_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [1:0]       step;
    logic [CH_W-1:0]         eff_active;
    logic                    wch_ok;
    logic                    at_detent;

    assign eff_active = (32'(active_channel) < 32'(NUM_CHANNELS)) ? active_channel : '0;
    assign wch_ok     = 32'(item.write_channel) < 32'(NUM_CHANNELS);
    assign step       = QUAD_STEPS[{last_pins_reg, item.pin_pair}];
    assign acc_sum    = acc_reg + ACC_W'(step);
    assign at_detent  = (acc_sum >= DETENT_POS) || (acc_sum <= DETENT_NEG);

    always_comb
    begin
        last_pins_next = last_pins_reg;
        acc_next       = acc_reg;
        cmd.load       = 1'b0;
        cmd.detent     = 1'b0;
        cmd.up         = !acc_sum[ACC_W-1];
        cmd.ch         = eff_active;
        cmd.load_freq  = item.write_freq;
        if (item.func == FUNC_DIRECT_LOAD)
        begin
            if (wch_ok)
            begin
                cmd.load = 1'b1;
                cmd.ch   = item.write_channel;
            end
        end
        else if (!item.tune_enable)
        begin
            last_pins_next = item.pin_pair;
        end
        else if (item.pin_pair != last_pins_reg)
        begin
            last_pins_next = item.pin_pair;
            if (at_detent)
            begin
                cmd.detent = 1'b1;
                acc_next   = '0;
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pins_reg <= '0;
            acc_reg       <= '0;
        end
        else if (fire)
        begin
            last_pins_reg <= last_pins_next;
            acc_reg       <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/qft_freq_bank.sv -----
// Per-channel frequency registers with detent add and range clamp.
// Depends on qft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qft_freq_bank #(
    parameter int NUM_CHANNELS = qft_pkg::DEF_NUM_CHANNELS
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                fire,
    input  wire qft_pkg::freq_cmd_t            cmd,
    input  wire signed [qft_pkg::STEP_W-1:0]   tuning_step,
    output logic       [qft_pkg::FREQ_W-1:0]   freq_out
);
    import qft_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SUM_W = FREQ_W + 2;
    localparam logic signed [SUM_W-1:0] MIN_S = {2'b00, FREQ_MIN};
    localparam logic signed [SUM_W-1:0] MAX_S = {2'b00, FREQ_MAX};

    logic [FREQ_W-1:0]       freq_reg [NUM_CHANNELS];
    logic [IDX_W+CH_W-1:0]   idx_wide;
    logic [IDX_W-1:0]        idx;
    logic [FREQ_W-1:0]       cur;
    logic signed [SUM_W-1:0] step_ext;
    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] sum;
    logic [FREQ_W-1:0]       tuned;
    logic [FREQ_W-1:0]       loaded;
    logic [FREQ_W-1:0]       freq_next;

    assign idx_wide = {{IDX_W{1'b0}}, cmd.ch};
    assign idx      = idx_wide[IDX_W-1:0];
    assign cur      = freq_reg[idx];

    assign step_ext = SUM_W'(tuning_step);
    assign delta    = cmd.up ? step_ext : -step_ext;
    assign sum      = $signed({2'b00, cur}) + delta;

    always_comb
    begin
        if (sum < MIN_S)
            tuned = FREQ_MIN;
        else if (sum > MAX_S)
            tuned = FREQ_MAX;
        else
            tuned = sum[FREQ_W-1:0];

        if (cmd.load_freq < FREQ_MIN)
            loaded = FREQ_MIN;
        else if (cmd.load_freq > FREQ_MAX)
            loaded = FREQ_MAX;
        else
            loaded = cmd.load_freq;

        if (cmd.load)
            freq_next = loaded;
        else if (cmd.detent)
            freq_next = tuned;
        else
            freq_next = cur;
    end

    // Value reported is the channel's frequency after this beat's update
    assign freq_out = freq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                freq_reg[i] <= reset_freq(i);
        end
        else if (fire && (cmd.load || cmd.detent))
        begin
            freq_reg[idx] <= freq_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/quadrature_frequency_tuner_core.sv -----
// Quadrature frequency tuner top level: config registers, input and result
// registers. Depends on qft_pkg, qft_intf, qft_step_dec, qft_freq_bank.
//
// Usage:
//   in_item  : valid/ready channel, one beat per encoder pin sample
//              (func = 0) or direct frequency write (func = 1).
//   out_res  : valid/ready channel, exactly one beat per input beat, in order:
//              reported channel, its frequency after the update, changed flag.
//   cfg_*    : write-only port; cfg_index 0 = active channel, 1 = tuning step.
//              Write only while no beat is in flight.
// Path: an accepted beat is held in the input register, then its result goes
//   through the decode/add/clamp pass into the result register, which drives out_res.
// Throughput: one beat per cycle sustained while out_res takes every result. The single
//   decode and one 30-bit add/clamp between the two registers set this figure.
// Stall: when out_res is held off, the result register holds; in_item.ready
//   stays high until the input register also fills, so two beats can sit
//   in the block during a stall.
// Reset: rst_n clears pin history and step sum, loads 10/14/21 MHz into
//   channels 0..2 (10 MHz beyond), active channel 0, step -100000 Hz.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_frequency_tuner_core #(
    parameter int NUM_CHANNELS     = qft_pkg::DEF_NUM_CHANNELS,
    parameter int STEPS_PER_DETENT = qft_pkg::DEF_STEPS_PER_DETENT
) (
    input  wire                            clk,
    input  wire                            rst_n,
    qft_item_if.sink                       in_item,
    qft_result_if.source                   out_res,
    input  wire                            cfg_we,
    input  wire  [qft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [qft_pkg::CFG_W-1:0]      cfg_wdata
);
    import qft_pkg::*;

    // Configuration registers
    logic [CH_W-1:0]          active_channel_reg;
    logic signed [STEP_W-1:0] tuning_step_reg;

    // Input stage
    logic  in_valid_reg;
    item_t item_reg;

    // Result stage
    logic              out_valid_reg;
    logic [CH_W-1:0]   out_channel_reg;
    logic [FREQ_W-1:0] out_freq_reg;
    logic              out_changed_reg;

    logic      out_free;   // result register can take a beat this cycle
    logic      fire;       // the held input beat is processed this cycle
    freq_cmd_t cmd;
    logic [FREQ_W-1:0] freq_now;

    assign out_free      = !out_valid_reg || out_res.ready;
    assign fire          = in_valid_reg && out_free;
    assign in_item.ready = !in_valid_reg || out_free;

    assign out_res.valid       = out_valid_reg;
    assign out_res.out_channel = out_channel_reg;
    assign out_res.out_freq    = out_freq_reg;
    assign out_res.changed     = out_changed_reg;

    qft_step_dec #(
        .NUM_CHANNELS     (NUM_CHANNELS),
        .STEPS_PER_DETENT (STEPS_PER_DETENT)
    ) u_step_dec (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .item           (item_reg),
        .active_channel (active_channel_reg),
        .cmd            (cmd)
    );

    qft_freq_bank #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_freq_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .cmd         (cmd),
        .tuning_step (tuning_step_reg),
        .freq_out    (freq_now)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_channel_reg <= '0;
            tuning_step_reg    <= TUNING_STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACTIVE_CHANNEL: active_channel_reg <= cfg_wdata[CH_W-1:0];
                CFG_TUNING_STEP:    tuning_step_reg    <= cfg_wdata[STEP_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_item.ready)
            in_valid_reg <= in_item.valid;
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (in_item.valid && in_item.ready)
        begin
            item_reg.func          <= in_item.func;
            item_reg.pin_pair      <= in_item.pin_pair;
            item_reg.tune_enable   <= in_item.tune_enable;
            item_reg.write_channel <= in_item.write_channel;
            item_reg.write_freq    <= in_item.write_freq;
        end
    end

    // Result register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= fire;
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_channel_reg <= cmd.ch;
            out_freq_reg    <= freq_now;
            out_changed_reg <= cmd.load || cmd.detent;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/qft_core_chk.sv -----
// Port-level checker for the quadrature frequency tuner, with its bind.
// Depends on qft_pkg and quadrature_frequency_tuner_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "quadrature_frequency_tuner_core_assert.svh"

module qft_core_chk #(
    parameter int NUM_CHANNELS = qft_pkg::DEF_NUM_CHANNELS
) (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_ready,
    input wire                          out_valid,
    input wire                          out_ready,
    input wire [qft_pkg::CH_W-1:0]      out_channel,
    input wire [qft_pkg::FREQ_W-1:0]    out_freq,
    input wire                          changed
);
    import qft_pkg::*;

    // Reported frequency always inside the clamp window
    `QFT_ASSERT_SAME(a_freq_range, clk, rst_n, out_valid,
                     (out_freq >= FREQ_MIN) && (out_freq <= FREQ_MAX))

    // Reported channel is always a real channel
    `QFT_ASSERT_SAME(a_chan_range, clk, rst_n, out_valid,
                     32'(out_channel) < 32'(NUM_CHANNELS))

    // With the result side empty the block must take input
    `QFT_ASSERT_SAME(a_no_false_stall, clk, rst_n, !out_valid, in_ready)

    // A stalled result holds
    `QFT_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(out_channel) && $stable(out_freq) && $stable(changed))

endmodule

bind quadrature_frequency_tuner_core qft_core_chk #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_qft_core_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_item.ready),
    .out_valid   (out_res.valid),
    .out_ready   (out_res.ready),
    .out_channel (out_res.out_channel),
    .out_freq    (out_res.out_freq),
    .changed     (out_res.changed)
);

`default_nettype wire

// ----- tb/quadrature_frequency_tuner_core_test.sv -----
// Self-checking testbench for quadrature_frequency_tuner_core: encoder pin
// samples and direct frequency writes against a shadow model of the tuner.
// Depends on qft_pkg, qft_intf and the RTL of the block.
`timescale 1ns / 1ps

localparam int TUNER_CHANNELS = 3;
localparam int DETENT_STEPS   = 4;

typedef struct packed {
    logic [qft_pkg::CH_W-1:0]   ch;
    logic [qft_pkg::FREQ_W-1:0] hz;
    logic                       changed;
} tuner_reading_t;

// Shadow copy of the tuner state; queues the reading each beat should produce.
class tuner_scoreboard;
    logic [qft_pkg::CH_W-1:0]          active_ch;
    logic signed [qft_pkg::STEP_W-1:0] detent_hz;
    logic [qft_pkg::PIN_W-1:0]         prev_pins;
    int                                step_sum;
    logic [qft_pkg::FREQ_W-1:0]        chan_hz [TUNER_CHANNELS];
    tuner_reading_t                    expected_readings [$];
    int errors;
    int checked;
    int loads;
    int detents;
    int clamps;

    function new();
        active_ch = '0;
        detent_hz = -25'sd100000;
        prev_pins = '0;
        step_sum  = 0;
        chan_hz[0] = 28'd10000000;
        chan_hz[1] = 28'd14000000;
        chan_hz[2] = 28'd21000000;
        errors  = 0;
        checked = 0;
        loads   = 0;
        detents = 0;
        clamps  = 0;
    endfunction

    function void set_active(logic [qft_pkg::CH_W-1:0] ch);
        active_ch = ch;
    endfunction

    function void set_step(logic [qft_pkg::CFG_W-1:0] bits);
        detent_hz = bits[qft_pkg::STEP_W-1:0];
    endfunction

    function int pending();
        return expected_readings.size();
    endfunction

    // Gray-code direction of one pin change; both pins flipping counts as none.
    function int pin_move(logic [1:0] from, logic [1:0] to);
        case ({from, to})
            4'b0001, 4'b0111, 4'b1110, 4'b1000: return 1;
            4'b0010, 4'b1011, 4'b1101, 4'b0100: return -1;
            default:                            return 0;
        endcase
    endfunction

    function logic [qft_pkg::FREQ_W-1:0] clamp_hz(longint hz);
        if (hz < longint'(qft_pkg::FREQ_MIN)) begin
            clamps++;
            return qft_pkg::FREQ_MIN;
        end
        if (hz > longint'(qft_pkg::FREQ_MAX)) begin
            clamps++;
            return qft_pkg::FREQ_MAX;
        end
        return qft_pkg::FREQ_W'(hz);
    endfunction

    function void note_item(qft_pkg::item_t it);
        int             ch;
        logic           chg;
        longint         hz;
        tuner_reading_t want;
        ch  = (active_ch < TUNER_CHANNELS) ? int'(active_ch) : 0;
        chg = 1'b0;
        if (it.func == qft_pkg::FUNC_DIRECT_LOAD) begin
            if (it.write_channel < TUNER_CHANNELS) begin
                ch = int'(it.write_channel);
                chan_hz[ch] = clamp_hz(longint'({36'd0, it.write_freq}));
                chg = 1'b1;
                loads++;
            end
        end else if (!it.tune_enable) begin
            prev_pins = it.pin_pair;
        end else if (it.pin_pair != prev_pins) begin
            step_sum += pin_move(prev_pins, it.pin_pair);
            prev_pins = it.pin_pair;
            if (step_sum >= DETENT_STEPS || step_sum <= -DETENT_STEPS) begin
                hz = longint'({36'd0, chan_hz[ch]});
                if (step_sum > 0)
                    hz += detent_hz;
                else
                    hz -= detent_hz;
                step_sum = 0;
                chan_hz[ch] = clamp_hz(hz);
                chg = 1'b1;
                detents++;
            end
        end
        want.ch      = qft_pkg::CH_W'(ch);
        want.hz      = chan_hz[ch];
        want.changed = chg;
        expected_readings.push_back(want);
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(tuner_reading_t got);
        tuner_reading_t want;
        checked++;
        if (expected_readings.size() == 0) begin
            report($sformatf("result %0d (ch %0d, %0d Hz) with nothing expected",
                             checked, got.ch, got.hz));
            return;
        end
        want = expected_readings.pop_front();
        if (got.ch !== want.ch)
            report($sformatf("result %0d: out_channel %0d, expected %0d",
                             checked, got.ch, want.ch));
        if (got.hz !== want.hz)
            report($sformatf("result %0d: out_freq %0d, expected %0d",
                             checked, got.hz, want.hz));
        if (got.changed !== want.changed)
            report($sformatf("result %0d: changed %0b, expected %0b",
                             checked, got.changed, want.changed));
    endtask
endclass

module quadrature_frequency_tuner_core_test;
    import qft_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_CYCLES     = 150;   // long output stall, fills the block
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no beat on either side

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    qft_item_if   item_ch ();
    qft_result_if res_ch ();

    tuner_scoreboard sb = new();

    // Shared pacing controls between the stimulus and the result sink.
    bit no_idle      = 1'b0;   // both sides run without gaps
    bit hold_pending = 1'b0;   // ask the sink for one long stall

    // Encoder position as the block should see it, plus the current turn.
    logic [PIN_W-1:0] enc_pos;
    bit               enc_up;
    int               burst_left = 0;

    int items_sent = 0;
    int settings   = 0;
    int idle_cycles = 0;

    always #10 clk = ~clk;

    quadrature_frequency_tuner_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (item_ch),
        .out_res   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Next pin pair one quarter step along the Gray sequence 0-1-3-2.
    function automatic logic [PIN_W-1:0] next_pins(logic [PIN_W-1:0] p, bit up);
        case (p)
            2'd0:    return up ? 2'd1 : 2'd2;
            2'd1:    return up ? 2'd3 : 2'd0;
            2'd3:    return up ? 2'd2 : 2'd1;
            default: return up ? 2'd0 : 2'd3;
        endcase
    endfunction

    function automatic item_t mk_item(logic f, logic [PIN_W-1:0] pins, logic tune,
                                      logic [CH_W-1:0] wch, logic [FREQ_W-1:0] whz);
        item_t it;
        it.func          = f;
        it.pin_pair      = pins;
        it.tune_enable   = tune;
        it.write_channel = wch;
        it.write_freq    = whz;
        return it;
    endfunction

    function automatic logic [FREQ_W-1:0] random_hz();
        case ($urandom_range(0, 3))
            0:       return FREQ_W'($urandom_range(0, 20000));
            1:       return FREQ_W'($urandom_range(219990000, 220010000));
            2:       return FREQ_W'($urandom);
            default: return FREQ_W'($urandom_range(10000, 220000000));
        endcase
    endfunction

    // Mostly clean turns in bursts of one direction, with contact bounce,
    // illegal jumps, tuning-off tracking and direct writes mixed in.
    // Unused fields always carry random bits.
    function automatic item_t random_item();
        item_t it;
        int    pick;
        it.func          = FUNC_PIN_SAMPLE;
        it.pin_pair      = PIN_W'($urandom);
        it.tune_enable   = 1'($urandom);
        it.write_channel = CH_W'($urandom);
        it.write_freq    = FREQ_W'($urandom);
        if (burst_left == 0) begin
            enc_up     = 1'($urandom);
            burst_left = $urandom_range(1, 24);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            enc_pos = next_pins(enc_pos, enc_up);
            burst_left--;
            it.pin_pair    = enc_pos;
            it.tune_enable = 1'b1;
        end else if (pick < 78) begin
            // bounce: same pins again
            it.pin_pair    = enc_pos;
            it.tune_enable = 1'b1;
        end else if (pick < 83) begin
            // any jump, both-pin flips among them
            enc_pos        = PIN_W'($urandom);
            it.pin_pair    = enc_pos;
            it.tune_enable = 1'b1;
        end else if (pick < 89) begin
            enc_pos        = PIN_W'($urandom);
            it.pin_pair    = enc_pos;
            it.tune_enable = 1'b0;
        end else begin
            it.func          = FUNC_DIRECT_LOAD;
            it.write_channel = CH_W'($urandom_range(0, 3));
            it.write_freq    = random_hz();
        end
        return it;
    endfunction

    // Offer one beat after a random gap; valid stays up into the next beat
    // when no gap follows, so it is never dropped and raised in one step.
    task automatic send_item(input item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.func          <= it.func;
        item_ch.pin_pair      <= it.pin_pair;
        item_ch.tune_enable   <= it.tune_enable;
        item_ch.write_channel <= it.write_channel;
        item_ch.write_freq    <= it.write_freq;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        sb.note_item(it);
        items_sent++;
    endtask

    // Block until every queued reading has come back.
    task automatic wait_results();
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Two back-to-back register writes; only called with nothing in flight.
    task automatic configure(input logic [CH_W-1:0] ch, input int step_hz);
        logic [CFG_W-1:0] step_bits;
        step_bits = CFG_W'(step_hz);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACTIVE_CHANNEL;
        cfg_wdata <= CFG_W'(ch);
        @(posedge clk);
        cfg_index <= CFG_TUNING_STEP;
        cfg_wdata <= step_bits;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_active(ch);
        sb.set_step(step_bits);
        settings++;
    endtask

    // Result sink: random back-pressure, one long stall on request.
    initial begin : result_sink
        int             gap;
        tuner_reading_t got;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_pending) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
            got.ch      = res_ch.out_channel;
            got.hz      = res_ch.out_freq;
            got.changed = res_ch.changed;
            sb.check_result(got);
        end
    end

    // Watchdog: the run is hung if no beat moves on either side for too long.
    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [CH_W-1:0] ph_ch   [PHASES];
        int              ph_step [PHASES];

        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_ACTIVE_CHANNEL;
        cfg_wdata             <= '0;
        item_ch.valid         <= 1'b0;
        item_ch.func          <= FUNC_PIN_SAMPLE;
        item_ch.pin_pair      <= '0;
        item_ch.tune_enable   <= 1'b0;
        item_ch.write_channel <= '0;
        item_ch.write_freq    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, on reset settings: channel 0, -100 kHz per detent.
        enc_pos = 2'd0;
        // pins unchanged from reset: no step
        send_item(mk_item(FUNC_PIN_SAMPLE, 2'd0, 1'b1, 2'd0, '0));
        // one full detent forward; unused write fields all ones
        repeat (4) begin
            enc_pos = next_pins(enc_pos, 1'b1);
            send_item(mk_item(FUNC_PIN_SAMPLE, enc_pos, 1'b1, 2'd3, '1));
        end
        // and one back
        repeat (4) begin
            enc_pos = next_pins(enc_pos, 1'b0);
            send_item(mk_item(FUNC_PIN_SAMPLE, enc_pos, 1'b1, 2'd0, '0));
        end
        // both pins flip: pins tracked, no step
        send_item(mk_item(FUNC_PIN_SAMPLE, 2'd3, 1'b1, 2'd0, '0));
        send_item(mk_item(FUNC_PIN_SAMPLE, 2'd0, 1'b1, 2'd0, '0));
        // tuning off: pins only tracked
        send_item(mk_item(FUNC_PIN_SAMPLE, 2'd2, 1'b0, 2'd0, '0));
        send_item(mk_item(FUNC_PIN_SAMPLE, 2'd0, 1'b0, 2'd0, '0));
        // direct writes across the clamp limits, and to a missing channel
        send_item(mk_item(FUNC_DIRECT_LOAD, 2'd3, 1'b1, 2'd1, '0));
        send_item(mk_item(FUNC_DIRECT_LOAD, 2'd0, 1'b0, 2'd2, '1));
        send_item(mk_item(FUNC_DIRECT_LOAD, 2'd1, 1'b0, 2'd0, 28'd9999));
        send_item(mk_item(FUNC_DIRECT_LOAD, 2'd2, 1'b1, 2'd0, 28'd220000001));
        send_item(mk_item(FUNC_DIRECT_LOAD, 2'd0, 1'b0, 2'd0, 28'd10000));
        send_item(mk_item(FUNC_DIRECT_LOAD, 2'd0, 1'b0, 2'd1, 28'd220000000));
        send_item(mk_item(FUNC_DIRECT_LOAD, 2'd0, 1'b0, 2'd3, 28'd5000000));
        // detent at the lower limit: value pinned, still flagged as changed
        repeat (4) begin
            enc_pos = next_pins(enc_pos, 1'b1);
            send_item(mk_item(FUNC_PIN_SAMPLE, enc_pos, 1'b1, 2'd0, '0));
        end
        send_item(mk_item(FUNC_DIRECT_LOAD, 2'd0, 1'b0, 2'd0, 28'd10000000));

        // Random phases, one register setting each: step extremes, zero,
        // an out-of-range active channel, random steps, back to reset value.
        ph_ch[0] = 2'd1; ph_step[0] = 10000000;
        ph_ch[1] = 2'd2; ph_step[1] = -10000000;
        ph_ch[2] = 2'd3; ph_step[2] = 1;
        ph_ch[3] = 2'd0; ph_step[3] = 0;
        ph_ch[4] = 2'd2; ph_step[4] = int'($urandom_range(0, 20000000)) - 10000000;
        ph_ch[5] = 2'd1; ph_step[5] = int'($urandom_range(0, 2000)) - 1000;
        ph_ch[6] = 2'd0; ph_step[6] = 10000000;
        ph_ch[7] = 2'd3; ph_step[7] = -100000;

        for (int p = 0; p < PHASES; p++) begin
            item_ch.valid <= 1'b0;
            wait_results();
            configure(ph_ch[p], ph_step[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // gap-free stretch every phase; in phase 1 the sink also
                // stalls long while the sender keeps offering beats
                no_idle = (n >= 150 && n < 200) || (p == 1 && n >= 60 && n < 100);
                if (p == 1 && n == 60)
                    hold_pending = 1'b1;
                // sender pause until the block has drained
                if (p == 3 && n == 120) begin
                    item_ch.valid <= 1'b0;
                    wait_results();
                end
                send_item(random_item());
            end
        end

        item_ch.valid <= 1'b0;
        no_idle = 1'b0;
        wait_results();
        repeat (4) @(posedge clk);

        $display("covered %0d beats under %0d register settings: %0d direct writes,",
                 items_sent, settings, sb.loads);
        $display("  %0d detents, %0d clamped values, %0d results checked, %0d mismatches",
                 sb.detents, sb.clamps, sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/qft_pkg.sv
rtl/core/qft_intf.sv
rtl/core/qft_step_dec.sv
rtl/core/qft_freq_bank.sv
rtl/core/quadrature_frequency_tuner_core.sv
rtl/core/qft_core_chk.sv
tb/quadrature_frequency_tuner_core_test.sv
